FILE: rtl/obmfg_pkg.sv
`timescale 1ns / 1ps

package obmfg_pkg;

    localparam logic [15:0] EMPTY_CM = 16'hFFFF;
    localparam int SCORE_W = 26;
    localparam logic signed [SCORE_W-1:0] SCORE_START = SCORE_W'(59994);

    localparam logic OP_FUSE  = 1'b0;
    localparam logic OP_GUIDE = 1'b1;

    localparam logic REG_KEEP  = 1'b0;
    localparam logic REG_GUIDE = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic signed [7:0] first_bin;
        logic signed [7:0] last_bin;
        logic [15:0]       reading_cm;
        logic [15:0]       sensor_max_cm;
        logic [15:0]       sensor_min_cm;
        logic [6:0]        setpoint_bin;
    } cmd_t;

    typedef struct packed {
        logic [6:0] best_bin;
        logic       moved;
        logic [7:0] bins_written;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_F_PREP,
        S_G_PREP,
        S_NORM,
        S_F_RD,
        S_F_CHK,
        S_G_RD,
        S_G_LD,
        S_G_PEN,
        S_G_S0,
        S_G_S1,
        S_G_S2,
        S_G_CMP,
        S_DONE
    } state_t;

    function automatic logic [15:0] eff_dist(input logic [15:0] d, input logic [15:0] keep);
        eff_dist = (d == EMPTY_CM) ? keep : d;
    endfunction

endpackage

FILE: rtl/obmfg_ram.sv
`timescale 1ns / 1ps

module obmfg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 60
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/obstacle_bin_map_fuse_and_guide_unit.sv
`timescale 1ns / 1ps

// Polar obstacle map of BINS bins with a fuse command and a guide command. Only one item is in
// flight: busy is high from the cycle after start is taken until the result has been shown. A
// fuse first wraps its first bin into the map with the shared adder, then reads and checks
// each bin of the span in turn; a dropped reading or an empty span goes straight to the result.
// A guide wraps the bin just below its search window the same way, then scores each candidate
// in a window whose half width is set in the guide register. Every candidate after the first
// takes its own read, load, penalty, score and compare steps, set by the one read port of the
// bin memory, the penalty multiply and the single shared adder that builds the score and
// compares it. The result is shown on rsp for exactly one cycle with done high; the receiver
// cannot hold it off, so it must take it in that cycle.
module obstacle_bin_map_fuse_and_guide_unit #(
    parameter int BINS = 60
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  obmfg_pkg::cmd_t    cmd,
    output logic               done,
    output obmfg_pkg::rsp_t    rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import obmfg_pkg::*;

    localparam int IDX_W = $clog2(BINS);
    localparam int CNT_W = $clog2(BINS + 1);
    localparam logic signed [8:0] BINS_N = 9'(BINS);
    localparam logic signed [9:0] BINS_C = 10'(BINS);

    state_t state_reg, state_next;

    logic [15:0]             keep_reg, keep_next;
    logic [4:0]              gb_reg, gb_next;
    logic [BINS-1:0]         valid_reg, valid_next;

    logic                    op_reg, op_next;
    logic signed [7:0]       first_reg, first_next;
    logic signed [7:0]       last_reg, last_next;
    logic [15:0]             reading_reg, reading_next;
    logic [15:0]             rng_reg, rng_next;
    logic [15:0]             mind_reg, mind_next;
    logic [6:0]              sp_reg, sp_next;
    logic signed [8:0]       norm_reg, norm_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [7:0]              written_reg, written_next;
    logic                    in_range_reg, in_range_next;
    logic [15:0]             w0_reg, w0_next;
    logic [15:0]             w1_reg, w1_next;
    logic [15:0]             w2_reg, w2_next;
    logic [IDX_W-1:0]        i1_reg, i1_next;
    logic [IDX_W-1:0]        i2_reg, i2_next;
    logic [1:0]              prime_reg, prime_next;
    logic [5:0]              cand_reg, cand_next;
    logic [4:0]              absk_reg, absk_next;
    logic                    neg_reg, neg_next;
    logic [17:0]             keep3_reg, keep3_next;
    logic signed [SCORE_W-1:0] acc_reg, acc_next;
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [6:0]              chosen_reg, chosen_next;
    logic                    rd_vld_reg;

    logic signed [SCORE_W-1:0] alu_a, alu_b, alu_res;
    logic                      alu_sub;

    logic [31:0]      ram_rdata;
    logic             ram_we;
    logic [31:0]      ram_wdata;
    logic [15:0]      rd_dist, rd_rng;
    logic [IDX_W-1:0] idx_inc;
    logic             norm_ok;
    logic             bin_take;
    logic             cfg_wr;
    logic [15:0]      clamped;
    logic signed [9:0] span;
    logic [22:0]      pen_prod;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            REG_KEEP:  prdata = {16'd0, keep_reg};
            REG_GUIDE: prdata = {27'd0, gb_reg};
            default:   prdata = 32'd0;
        endcase
    end

    obmfg_ram #(
        .WIDTH (32),
        .DEPTH (BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_dist   = rd_vld_reg ? ram_rdata[15:0]  : EMPTY_CM;
    assign rd_rng    = rd_vld_reg ? ram_rdata[31:16] : 16'd0;
    assign ram_wdata = {rng_reg, reading_reg};
    assign idx_inc   = (idx_reg == IDX_W'(BINS - 1)) ? '0 : idx_reg + 1'b1;
    assign norm_ok   = !norm_reg[8] && (norm_reg < BINS_N);
    assign clamped   = (reading_reg > rng_reg) ? rng_reg : reading_reg;
    assign span      = 10'(last_reg) - 10'(first_reg) + 10'sd1;
    assign pen_prod  = 23'(keep3_reg) * 23'(absk_reg);

    always_comb
    begin
        if (in_range_reg)
        begin
            bin_take = (rd_dist >= rd_rng) || (rng_reg <= rd_rng);
        end
        else
        begin
            bin_take = ((rd_dist >= rd_rng) && (rng_reg >= rd_rng))
                    || ((rd_dist < rd_rng) && (rng_reg == rd_rng));
        end
    end

    // Shared adder and subtractor for wrapping, score build-up and compare.
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            S_NORM:
            begin
                alu_a   = SCORE_W'(norm_reg);
                alu_b   = SCORE_W'(BINS);
                alu_sub = !norm_reg[8];
            end
            S_G_S0:  alu_b = SCORE_W'({eff_dist(w0_reg, keep_reg), 1'b0});
            S_G_S1:  alu_b = SCORE_W'({w1_reg, 3'b000});
            S_G_S2:  alu_b = SCORE_W'({eff_dist(w2_reg, keep_reg), 1'b0});
            S_G_CMP: alu_b = best_reg;
            default: alu_b = '0;
        endcase
        alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + SCORE_W'(alu_sub);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (cmd.opcode == OP_GUIDE) ? S_G_PREP : S_F_PREP;
                end
            end
            S_F_PREP:
            begin
                if ((clamped > mind_reg) && (span > 10'sd0))
                begin
                    state_next = S_NORM;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_G_PREP: state_next = S_NORM;
            S_NORM:
            begin
                if (norm_ok)
                begin
                    state_next = (op_reg == OP_GUIDE) ? S_G_RD : S_F_RD;
                end
            end
            S_F_RD:  state_next = S_F_CHK;
            S_F_CHK: state_next = (cnt_reg == CNT_W'(1)) ? S_DONE : S_F_RD;
            S_G_RD:  state_next = S_G_LD;
            S_G_LD:  state_next = (prime_reg == 2'd2) ? S_G_PEN : S_G_RD;
            S_G_PEN: state_next = S_G_S0;
            S_G_S0:  state_next = S_G_S1;
            S_G_S1:  state_next = S_G_S2;
            S_G_S2:  state_next = S_G_CMP;
            S_G_CMP: state_next = (cand_reg == 6'd0) ? S_DONE : S_G_RD;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != S_IDLE);
        done = (state_reg == S_DONE);
        rsp  = '0;
        if (op_reg == OP_GUIDE)
        begin
            rsp.best_bin = chosen_reg;
            rsp.moved    = (chosen_reg != sp_reg);
        end
        else
        begin
            rsp.bins_written = written_reg;
        end
    end

    always_comb
    begin
        keep_next     = keep_reg;
        gb_next       = gb_reg;
        valid_next    = valid_reg;
        op_next       = op_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        reading_next  = reading_reg;
        rng_next      = rng_reg;
        mind_next     = mind_reg;
        sp_next       = sp_reg;
        norm_next     = norm_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        written_next  = written_reg;
        in_range_next = in_range_reg;
        w0_next       = w0_reg;
        w1_next       = w1_reg;
        w2_next       = w2_reg;
        i1_next       = i1_reg;
        i2_next       = i2_reg;
        prime_next    = prime_reg;
        cand_next     = cand_reg;
        absk_next     = absk_reg;
        neg_next      = neg_reg;
        keep3_next    = keep3_reg;
        acc_next      = acc_reg;
        best_next     = best_reg;
        chosen_next   = chosen_reg;
        ram_we        = 1'b0;

        if (cfg_wr)
        begin
            case (paddr[2])
                REG_KEEP:  keep_next = pwdata[15:0];
                REG_GUIDE: gb_next   = pwdata[4:0];
                default:   keep_next = keep_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next      = cmd.opcode;
                    first_next   = cmd.first_bin;
                    last_next    = cmd.last_bin;
                    reading_next = cmd.reading_cm;
                    rng_next     = cmd.sensor_max_cm;
                    mind_next    = cmd.sensor_min_cm;
                    sp_next      = cmd.setpoint_bin;
                end
            end
            S_F_PREP:
            begin
                reading_next  = clamped;
                in_range_next = (reading_reg < rng_reg);
                norm_next     = 9'(first_reg);
                cnt_next      = (span > BINS_C) ? CNT_W'(BINS) : span[CNT_W-1:0];
                written_next  = 8'd0;
            end
            S_G_PREP:
            begin
                norm_next   = $signed({2'b00, sp_reg}) - $signed({4'b0000, gb_reg}) - 9'sd1;
                keep3_next  = {2'b00, keep_reg} + {1'b0, keep_reg, 1'b0};
                absk_next   = gb_reg;
                neg_next    = (gb_reg != 5'd0);
                cand_next   = {gb_reg, 1'b0};
                prime_next  = 2'd0;
                best_next   = SCORE_START;
                chosen_next = sp_reg;
            end
            S_NORM:
            begin
                if (norm_ok)
                begin
                    idx_next = norm_reg[IDX_W-1:0];
                end
                else
                begin
                    norm_next = alu_res[8:0];
                end
            end
            S_F_CHK:
            begin
                if (bin_take)
                begin
                    ram_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    written_next        = written_reg + 8'd1;
                end
                idx_next = idx_inc;
                cnt_next = cnt_reg - 1'b1;
            end
            S_G_LD:
            begin
                w0_next  = w1_reg;
                w1_next  = w2_reg;
                w2_next  = rd_dist;
                i1_next  = i2_reg;
                i2_next  = idx_reg;
                idx_next = idx_inc;
                if (prime_reg != 2'd2)
                begin
                    prime_next = prime_reg + 2'd1;
                end
            end
            S_G_PEN: acc_next = $signed(SCORE_W'(pen_prod));
            S_G_S0:  acc_next = alu_res;
            S_G_S1:  acc_next = alu_res;
            S_G_S2:  acc_next = alu_res;
            S_G_CMP:
            begin
                if (alu_res[SCORE_W-1] && (w1_reg != EMPTY_CM))
                begin
                    best_next   = acc_reg;
                    chosen_next = 7'(i1_reg);
                end
                if (cand_reg != 6'd0)
                begin
                    cand_next = cand_reg - 6'd1;
                    if (neg_reg)
                    begin
                        if (absk_reg == 5'd1)
                        begin
                            neg_next = 1'b0;
                        end
                        absk_next = absk_reg - 5'd1;
                    end
                    else
                    begin
                        absk_next = absk_reg + 5'd1;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            keep_reg  <= '0;
            gb_reg    <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            keep_reg  <= keep_next;
            gb_reg    <= gb_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        reading_reg  <= reading_next;
        rng_reg      <= rng_next;
        mind_reg     <= mind_next;
        sp_reg       <= sp_next;
        norm_reg     <= norm_next;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        written_reg  <= written_next;
        in_range_reg <= in_range_next;
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        i1_reg       <= i1_next;
        i2_reg       <= i2_next;
        prime_reg    <= prime_next;
        cand_reg     <= cand_next;
        absk_reg     <= absk_next;
        neg_reg      <= neg_next;
        keep3_reg    <= keep3_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        chosen_reg   <= chosen_next;
        rd_vld_reg   <= valid_reg[idx_reg];
    end

endmodule

FILE: rtl/obmfg_checker.sv
`timescale 1ns / 1ps

module obmfg_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input obmfg_pkg::rsp_t rsp
);

    import obmfg_pkg::*;

    // A result is shown for one cycle only.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // An accepted item makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted without the block turning busy");

    // Results appear only while an item is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result shown while idle");

    // The block leaves busy only right after showing a result.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

    // A guide result that moved never reports written bins.
    a_moved_guide: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.moved) |-> (rsp.bins_written == 8'd0))
        else $error("moved set on a fuse result");

endmodule

bind obstacle_bin_map_fuse_and_guide_unit obmfg_checker u_obmfg_checker (.*);

FILE: dv/bin_map_checker.sv
`timescale 1ns / 1ps

module bin_map_checker #(
    parameter int BINS = 60
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  obmfg_pkg::cmd_t cmd,
    input  logic            done,
    input  obmfg_pkg::rsp_t rsp,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    input  logic [31:0]     prdata,
    input  logic            pready,
    output int              fail_count,
    output int              outstanding
);

    import obmfg_pkg::*;

    localparam longint GUIDE_SCORE_START = 59994;

    logic [15:0] bin_dist [BINS];
    logic [15:0] bin_rng [BINS];
    logic [15:0] keep_cm;
    logic [4:0]  guide_half;

    rsp_t        rsp_due [$];
    rsp_t        want;
    logic [31:0] reg_want;

    function automatic int bin_wrap_index(input longint i);
        longint m;
        m = i % BINS;
        if (m < 0)
        begin
            m = m + BINS;
        end
        return int'(m);
    endfunction

    function automatic rsp_t map_step(input cmd_t c);
        rsp_t        r;
        int          first;
        int          last;
        int          cnt;
        int          b;
        int          nb;
        logic [15:0] rd;
        logic [15:0] rng;
        logic        in_rng;
        logic        ok;
        longint      sp;
        longint      k;
        longint      j;
        longint      gl;
        longint      keep_l;
        longint      dv;
        longint      sum3;
        longint      score;
        longint      best;
        longint      chosen;
        r = '0;
        if (c.opcode == OP_FUSE)
        begin
            first = $signed(c.first_bin);
            last = $signed(c.last_bin);
            rd = c.reading_cm;
            rng = c.sensor_max_cm;
            if (rd > rng)
            begin
                rd = rng;
            end
            if (rd > c.sensor_min_cm && last >= first)
            begin
                cnt = last - first + 1;
                if (cnt > BINS)
                begin
                    cnt = BINS;
                end
                in_rng = rd < rng;
                for (int n = 0; n < cnt; n++)
                begin
                    b = bin_wrap_index(first + n);
                    if (in_rng)
                    begin
                        ok = (bin_dist[b] >= bin_rng[b]) || (rng <= bin_rng[b]);
                    end
                    else
                    begin
                        ok = (bin_dist[b] >= bin_rng[b] && rng >= bin_rng[b])
                             || (bin_dist[b] < bin_rng[b] && rng == bin_rng[b]);
                    end
                    if (ok)
                    begin
                        bin_dist[b] = rd;
                        bin_rng[b] = rng;
                        r.bins_written = r.bins_written + 8'd1;
                    end
                end
            end
        end
        else
        begin
            sp = longint'(c.setpoint_bin);
            gl = longint'(guide_half);
            keep_l = longint'(keep_cm);
            best = GUIDE_SCORE_START;
            chosen = sp;
            for (k = -gl; k <= gl; k++)
            begin
                b = bin_wrap_index(sp + k);
                sum3 = 0;
                for (j = -1; j <= 1; j++)
                begin
                    nb = bin_wrap_index(sp + k + j);
                    dv = (bin_dist[nb] == EMPTY_CM) ? keep_l : longint'(bin_dist[nb]);
                    sum3 = sum3 + dv;
                end
                score = 3 * keep_l * (k < 0 ? -k : k) - 2 * sum3
                        - 6 * longint'(bin_dist[b]);
                if (score < best && bin_dist[b] != EMPTY_CM)
                begin
                    best = score;
                    chosen = b;
                end
            end
            r.best_bin = chosen[6:0];
            r.moved = (chosen != sp);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BINS; i++)
            begin
                bin_dist[i] = EMPTY_CM;
                bin_rng[i] = '0;
            end
            keep_cm = '0;
            guide_half = '0;
            rsp_due.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_KEEP)
                    begin
                        keep_cm = pwdata[15:0];
                    end
                    else
                    begin
                        guide_half = pwdata[4:0];
                    end
                end
                else
                begin
                    reg_want = (paddr[2] == REG_KEEP) ? {16'd0, keep_cm} : {27'd0, guide_half};
                    if (prdata !== reg_want)
                    begin
                        $error("prdata: expected %0h, got %0h", reg_want, prdata);
                        fail_count++;
                    end
                end
            end
            if (done)
            begin
                if (rsp_due.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (rsp.best_bin !== want.best_bin)
                    begin
                        $error("best_bin: expected %0d, got %0d", want.best_bin, rsp.best_bin);
                        fail_count++;
                    end
                    if (rsp.moved !== want.moved)
                    begin
                        $error("moved: expected %0d, got %0d", want.moved, rsp.moved);
                        fail_count++;
                    end
                    if (rsp.bins_written !== want.bins_written)
                    begin
                        $error("bins_written: expected %0d, got %0d",
                               want.bins_written, rsp.bins_written);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                rsp_due.push_back(map_step(cmd));
            end
            outstanding <= rsp_due.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import obmfg_pkg::*;

    localparam int BINS = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    cmd_t        cmd = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy;
    logic        done;
    rsp_t        rsp;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    int          idle_pct = 0;

    always #6 clk = ~clk;

    obstacle_bin_map_fuse_and_guide_unit #(
        .BINS(BINS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    bin_map_checker #(
        .BINS(BINS)
    ) u_check (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .done(done),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .fail_count(fail_count),
        .outstanding(outstanding)
    );

    function automatic cmd_t noise_cmd();
        logic [95:0] raw;
        cmd_t        c;
        raw = {$urandom, $urandom, $urandom};
        c = raw[$bits(cmd_t)-1:0];
        return c;
    endfunction

    function automatic cmd_t fuse_cmd(input int first, input int last, input int rd,
                                      input int rng, input int mn);
        cmd_t c;
        c = noise_cmd();
        c.opcode = OP_FUSE;
        c.first_bin = first[7:0];
        c.last_bin = last[7:0];
        c.reading_cm = rd[15:0];
        c.sensor_max_cm = rng[15:0];
        c.sensor_min_cm = mn[15:0];
        return c;
    endfunction

    function automatic cmd_t guide_cmd(input int sp);
        cmd_t c;
        c = noise_cmd();
        c.opcode = OP_GUIDE;
        c.setpoint_bin = sp[6:0];
        return c;
    endfunction

    function automatic cmd_t rand_fuse();
        cmd_t c;
        int   first;
        int   span;
        int   last;
        int   rng;
        int   rd;
        int   mn;
        int   pick;
        if ($urandom_range(99) < 10)
        begin
            c = noise_cmd();
            c.opcode = OP_FUSE;
            return c;
        end
        first = ($urandom_range(99) < 80) ? $urandom_range(0, BINS - 1)
                                          : int'($urandom_range(0, 255)) - 128;
        span = ($urandom_range(99) < 85) ? $urandom_range(0, 12) : $urandom_range(0, 140);
        last = first + span - 1;
        if (last > 127)
        begin
            last = 127;
        end
        case ($urandom_range(3))
            0: rng = 1000;
            1: rng = 2500;
            2: rng = 4000;
            default: rng = $urandom_range(1, 65535);
        endcase
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            rd = rng + $urandom_range(0, 300);
            if (rd > 65535)
            begin
                rd = 65535;
            end
        end
        else if (pick < 90)
        begin
            rd = $urandom_range(0, rng);
        end
        else
        begin
            rd = 65535;
            rng = 65535;
        end
        mn = ($urandom_range(99) < 80) ? $urandom_range(0, 150) : $urandom_range(0, 65535);
        return fuse_cmd(first, last, rd, rng, mn);
    endfunction

    function automatic cmd_t rand_guide();
        cmd_t c;
        if ($urandom_range(99) < 10)
        begin
            c = noise_cmd();
            c.opcode = OP_GUIDE;
            return c;
        end
        return guide_cmd(($urandom_range(99) < 88) ? $urandom_range(0, BINS - 1)
                                                   : $urandom_range(BINS, 127));
    endfunction

    task automatic send_item(input cmd_t c);
        int gap;
        gap = 0;
        while (gap < 100 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (busy !== 1'b0);
            repeat (gap - 1) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic settle(input int extra);
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy !== 1'b0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic reg_access(input logic idx, input logic wr, input logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input int keep, input int half);
        reg_access(REG_KEEP, 1'b1, keep);
        reg_access(REG_KEEP, 1'b0, '0);
        reg_access(REG_GUIDE, 1'b1, half);
        reg_access(REG_GUIDE, 1'b0, '0);
    endtask

    initial
    begin
        int keep;
        int half;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(guide_cmd(0));
        send_item(guide_cmd(127));
        send_item(fuse_cmd(0, 59, 500, 1000, 10));
        send_item(fuse_cmd(-128, 127, 65534, 65534, 0));
        send_item(fuse_cmd(5, 4, 700, 1000, 0));
        send_item(fuse_cmd(20, 25, 100, 1000, 100));
        send_item(fuse_cmd(20, 25, 0, 1000, 0));
        send_item(fuse_cmd(20, 25, 3000, 1000, 0));
        send_item(fuse_cmd(30, 35, 800, 2000, 0));
        send_item(fuse_cmd(30, 35, 800, 500, 0));
        send_item(fuse_cmd(30, 32, 65535, 65535, 0));
        send_item(fuse_cmd(55, 64, 700, 1000, 0));
        send_item(fuse_cmd(-3, 2, 400, 1000, 0));
        send_item(fuse_cmd(127, 127, 300, 1000, 0));
        send_item(guide_cmd(10));
        settle(8);
        set_regs(65535, 30);
        send_item(guide_cmd(0));
        send_item(guide_cmd(31));
        send_item(guide_cmd(127));
        send_item(guide_cmd(59));
        send_item(fuse_cmd(40, 44, 65535, 65535, 65534));

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin keep = 0; half = 0; idle_pct = 0; end
                1: begin keep = 65535; half = 30; idle_pct = 81; end
                2: begin keep = $urandom_range(0, 2000); half = $urandom_range(1, 6);
                         idle_pct = 6; end
                3: begin keep = $urandom_range(0, 65535); half = $urandom_range(0, 10);
                         idle_pct = 0; end
                4: begin keep = 300; half = 3; idle_pct = 81; end
                default: begin keep = $urandom_range(0, 65535); half = $urandom_range(0, 30);
                               idle_pct = 6; end
            endcase
            settle(8);
            set_regs(keep, half);
            repeat (158)
            begin
                send_item(($urandom_range(99) < 55) ? rand_fuse() : rand_guide());
            end
        end

        settle(500);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("** obstacle_bin_map_fuse_and_guide_unit: PASSED **");
        end
        else
        begin
            $display("** obstacle_bin_map_fuse_and_guide_unit: FAILED **");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("** obstacle_bin_map_fuse_and_guide_unit: FAILED **");
        $finish;
    end

endmodule
